// ----- hw/rtl/gda_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_pkg
// Shared types, constants and calendar tables of the Gregorian date unit.
// ----------------------------------------------------------------------------
package gda_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int FUNC_W  = 2;
  localparam int OFF_W   = 22;
  localparam int DIFF_W  = 23;
  localparam int ACC_W   = 25;

  // serial day number arithmetic
  localparam int YEAR_OFFSET   = 399;
  localparam int DAYS_PER_YEAR = 365;
  localparam int RECIP_100     = 5243;
  localparam int RECIP_SHIFT   = 19;
  localparam int SERIAL_BASE   = 146097;
  localparam int SPAN_MAX      = 3652059;

  localparam int P_W    = 15;
  localparam int PROD_W = 23;
  localparam int PQ4_W  = P_W - 2;
  localparam int Q_W    = 8;
  localparam int Q400_W = Q_W - 2;
  localparam int MUL_W  = RECIP_SHIFT + Q_W;
  localparam int TAIL_W = 11;
  localparam int LEN_W  = 9;
  localparam int MIDX_W = 4;
  localparam int M100_W = 7;
  localparam int M400_W = 9;

  localparam logic [MIDX_W-1:0] LAST_MONTH = MIDX_W'(11);
  localparam logic [M100_W-1:0] MOD100_TOP = M100_W'(99);
  localparam logic [M400_W-1:0] MOD400_TOP = M400_W'(399);

  localparam logic signed [ACC_W-1:0] DIFF_HI = ACC_W'((1 <<< (DIFF_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] DIFF_LO = ACC_W'(-(1 <<< (DIFF_W - 1)));

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD  = 2'd0,
    FUNC_SUB  = 2'd1,
    FUNC_DIFF = 2'd2,
    FUNC_CMP  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ALU_HOLD,
    ALU_LOAD,
    ALU_ADD,
    ALU_SUB,
    ALU_CSUB
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_T0,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_T4,
    ST_OFF,
    ST_BASE,
    ST_CHECK,
    ST_YEAR,
    ST_MONTH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [OFF_W-1:0]   offset_days;
    logic [YEAR_W-1:0]  other_year;
    logic [MONTH_W-1:0] other_month;
    logic [DAY_W-1:0]   other_day;
  } in_item_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  result_year;
    logic [MONTH_W-1:0] result_month;
    logic [DAY_W-1:0]   result_day;
    logic [DIFF_W-1:0]  days_between;
    logic               is_less;
    logic               is_equal;
    logic               status;
  } out_item_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    logic [PROD_W-1:0]        prod365;
    logic [PQ4_W-1:0]         p_q4;
    logic [Q_W-1:0]           q100;
    logic [Q400_W-1:0]        q400;
    logic signed [TAIL_W-1:0] tail;
  } terms_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ACC_W-1:0] operand;
  } alu_ctrl_t;

  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic             ge;
  } alu_stat_t;

  // month 0 counts as january, 13 to 15 as december
  function automatic logic [MIDX_W-1:0] month_index(input logic [MONTH_W-1:0] m);
    logic [MIDX_W-1:0] idx;
    if (m == '0) begin
      idx = '0;
    end else if (m > MONTH_W'(12)) begin
      idx = LAST_MONTH;
    end else begin
      idx = MIDX_W'(m - MONTH_W'(1));
    end
    return idx;
  endfunction

  function automatic logic [LEN_W-1:0] days_before(input logic [MIDX_W-1:0] idx);
    logic [LEN_W-1:0] v;
    case (idx)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MIDX_W-1:0] idx);
    logic [DAY_W-1:0] v;
    case (idx)
      4'd1:                   v = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: v = 5'd30;
      default:                v = 5'd31;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/gda_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_in_if
// Request channel of the date unit: valid, ready and one input item.
// ----------------------------------------------------------------------------
interface gda_in_if;

  logic              valid;
  logic              ready;
  gda_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// ----- hw/rtl/gda_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_out_if
// Result channel of the date unit: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface gda_out_if;

  logic               valid;
  logic               ready;
  gda_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// ----- hw/rtl/gda_terms.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_terms
// Two register stages that split a date into the partial terms of its
// serial day number, using reciprocal multiplies for the century counts.
// ----------------------------------------------------------------------------
module gda_terms (
  input  logic             clk,
  input  logic             load,
  input  gda_pkg::date_t   date,
  output gda_pkg::terms_t  terms
);

  logic [gda_pkg::P_W-1:0]    p;
  logic [gda_pkg::PROD_W:0]   prod_full;
  logic [gda_pkg::MUL_W-1:0]  qp_full;
  logic [gda_pkg::MUL_W-1:0]  qy_full;

  logic [gda_pkg::PROD_W-1:0]  prod365;
  logic [gda_pkg::PQ4_W-1:0]   p_q4;
  logic [gda_pkg::Q_W-1:0]     qp100;
  logic [gda_pkg::Q_W-1:0]     qy100;
  logic [gda_pkg::YEAR_W-1:0]  year;
  logic [gda_pkg::MIDX_W-1:0]  midx;
  logic [gda_pkg::DAY_W-1:0]   day;
  logic signed [gda_pkg::TAIL_W-1:0] tail;

  logic [gda_pkg::P_W-1:0]    y100;
  logic                       cent;
  logic                       leap;
  logic [gda_pkg::TAIL_W-1:0] tail_next;

  always_comb begin
    p         = gda_pkg::P_W'(date.year) + gda_pkg::P_W'(gda_pkg::YEAR_OFFSET);
    prod_full = (gda_pkg::PROD_W+1)'(p) * (gda_pkg::PROD_W+1)'(gda_pkg::DAYS_PER_YEAR);
    qp_full   = gda_pkg::MUL_W'(p) * gda_pkg::MUL_W'(gda_pkg::RECIP_100);
    qy_full   = gda_pkg::MUL_W'(date.year) * gda_pkg::MUL_W'(gda_pkg::RECIP_100);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod365 <= prod_full[gda_pkg::PROD_W-1:0];
      p_q4    <= p[gda_pkg::P_W-1:2];
      qp100   <= qp_full[gda_pkg::MUL_W-1:gda_pkg::RECIP_SHIFT];
      qy100   <= qy_full[gda_pkg::MUL_W-1:gda_pkg::RECIP_SHIFT];
      year    <= date.year;
      midx    <= gda_pkg::month_index(date.month);
      day     <= date.day;
    end
  end

  // leap test of the year, then day of year minus one
  always_comb begin
    y100      = gda_pkg::P_W'(qy100) * gda_pkg::P_W'(100);
    cent      = (y100 == gda_pkg::P_W'(year));
    leap      = ((year[1:0] == 2'd0) && !cent) || (cent && (qy100[1:0] == 2'd0));
    tail_next = gda_pkg::TAIL_W'(gda_pkg::days_before(midx))
              + gda_pkg::TAIL_W'(leap && (midx >= gda_pkg::MIDX_W'(2)))
              + gda_pkg::TAIL_W'(day) - gda_pkg::TAIL_W'(1);
  end

  always_ff @(posedge clk) begin
    tail <= $signed(tail_next);
  end

  always_comb begin
    terms.prod365 = prod365;
    terms.p_q4    = p_q4;
    terms.q100    = qp100;
    terms.q400    = qp100[gda_pkg::Q_W-1:2];
    terms.tail    = tail;
  end

endmodule

// ----- hw/rtl/gda_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_alu
// Shared accumulator with one adder: load, add, subtract, compare and
// subtract-if-not-below, used by the arithmetic steps of the sequencer.
// ----------------------------------------------------------------------------
module gda_alu (
  input  logic                clk,
  input  gda_pkg::alu_ctrl_t  ctrl,
  output gda_pkg::alu_stat_t  stat
);

  logic signed [gda_pkg::ACC_W-1:0] acc;
  logic signed [gda_pkg::ACC_W-1:0] addend;
  logic signed [gda_pkg::ACC_W-1:0] sum;
  logic                             subtract;

  always_comb begin
    subtract = (ctrl.op != gda_pkg::ALU_ADD);
    addend   = subtract ? -$signed(ctrl.operand) : $signed(ctrl.operand);
    sum      = acc + addend;
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      gda_pkg::ALU_LOAD: acc <= $signed(ctrl.operand);
      gda_pkg::ALU_ADD:  acc <= sum;
      gda_pkg::ALU_SUB:  acc <= sum;
      gda_pkg::ALU_CSUB: begin
        if (!sum[gda_pkg::ACC_W-1]) begin
          acc <= sum;
        end
      end
      default: acc <= acc;
    endcase
  end

  always_comb begin
    stat.acc = acc;
    stat.ge  = !sum[gda_pkg::ACC_W-1];
  end

endmodule

// ----- hw/rtl/gda_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_ctrl
// Sequencer of the date unit: builds serial day numbers on the shared
// accumulator, walks years and months back to a date, and forms the result.
// ----------------------------------------------------------------------------
module gda_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  gda_pkg::in_item_t   in_data,
  output logic                in_ready,
  output gda_pkg::date_t      sel_date,
  output logic                term_load,
  input  gda_pkg::terms_t     terms,
  output gda_pkg::alu_ctrl_t  alu_ctrl,
  input  gda_pkg::alu_stat_t  alu_stat,
  output logic                res_valid,
  output gda_pkg::out_item_t  res,
  input  logic                res_ready
);

  gda_pkg::state_t state;
  gda_pkg::state_t state_next;

  gda_pkg::in_item_t             item;
  logic                          second;
  logic                          oor;
  logic [gda_pkg::YEAR_W-1:0]    year_cnt;
  logic [1:0]                    mod4;
  logic [gda_pkg::M100_W-1:0]    mod100;
  logic [gda_pkg::M400_W-1:0]    mod400;
  logic [gda_pkg::MIDX_W-1:0]    mon;

  logic                          leap;
  logic [gda_pkg::LEN_W-1:0]     year_len;
  logic [gda_pkg::DAY_W-1:0]     mon_len;
  logic signed [gda_pkg::ACC_W-1:0] acc_s;

  always_comb begin
    leap     = ((mod4 == 2'd0) && (mod100 != '0)) || (mod400 == '0);
    year_len = gda_pkg::LEN_W'(gda_pkg::DAYS_PER_YEAR) + gda_pkg::LEN_W'(leap);
    mon_len  = gda_pkg::month_len(mon)
             + gda_pkg::DAY_W'(leap && (mon == gda_pkg::MIDX_W'(1)));
    acc_s    = $signed(alu_stat.acc);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gda_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_data.func == gda_pkg::FUNC_CMP) ? gda_pkg::ST_FINISH
                                                           : gda_pkg::ST_PREP;
        end
      end
      gda_pkg::ST_PREP: state_next = gda_pkg::ST_T0;
      gda_pkg::ST_T0:   state_next = gda_pkg::ST_T1;
      gda_pkg::ST_T1:   state_next = gda_pkg::ST_T2;
      gda_pkg::ST_T2:   state_next = gda_pkg::ST_T3;
      gda_pkg::ST_T3:   state_next = gda_pkg::ST_T4;
      gda_pkg::ST_T4: begin
        if (item.func == gda_pkg::FUNC_DIFF) begin
          state_next = second ? gda_pkg::ST_FINISH : gda_pkg::ST_PREP;
        end else begin
          state_next = gda_pkg::ST_OFF;
        end
      end
      gda_pkg::ST_OFF:  state_next = gda_pkg::ST_BASE;
      gda_pkg::ST_BASE: state_next = gda_pkg::ST_CHECK;
      gda_pkg::ST_CHECK: begin
        state_next = (alu_stat.acc[gda_pkg::ACC_W-1] || alu_stat.ge) ? gda_pkg::ST_FINISH
                                                                     : gda_pkg::ST_YEAR;
      end
      gda_pkg::ST_YEAR: begin
        if (!alu_stat.ge) begin
          state_next = gda_pkg::ST_MONTH;
        end
      end
      gda_pkg::ST_MONTH: begin
        if (!alu_stat.ge || (mon == gda_pkg::LAST_MONTH)) begin
          state_next = gda_pkg::ST_FINISH;
        end
      end
      gda_pkg::ST_FINISH: begin
        if (res_ready) begin
          state_next = gda_pkg::ST_IDLE;
        end
      end
      default: state_next = gda_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready         = (state == gda_pkg::ST_IDLE);
    term_load        = (state == gda_pkg::ST_PREP);
    res_valid        = (state == gda_pkg::ST_FINISH);
    alu_ctrl.op      = gda_pkg::ALU_HOLD;
    alu_ctrl.operand = '0;
    if (second) begin
      sel_date = '{year: item.other_year, month: item.other_month, day: item.other_day};
    end else begin
      sel_date = '{year: item.year, month: item.month, day: item.day};
    end

    case (state)
      gda_pkg::ST_T0: begin
        alu_ctrl.op      = second ? gda_pkg::ALU_SUB : gda_pkg::ALU_LOAD;
        alu_ctrl.operand = gda_pkg::ACC_W'(terms.prod365);
      end
      gda_pkg::ST_T1: begin
        alu_ctrl.op      = second ? gda_pkg::ALU_SUB : gda_pkg::ALU_ADD;
        alu_ctrl.operand = gda_pkg::ACC_W'(terms.p_q4);
      end
      gda_pkg::ST_T2: begin
        alu_ctrl.op      = second ? gda_pkg::ALU_ADD : gda_pkg::ALU_SUB;
        alu_ctrl.operand = gda_pkg::ACC_W'(terms.q100);
      end
      gda_pkg::ST_T3: begin
        alu_ctrl.op      = second ? gda_pkg::ALU_SUB : gda_pkg::ALU_ADD;
        alu_ctrl.operand = gda_pkg::ACC_W'(terms.q400);
      end
      gda_pkg::ST_T4: begin
        alu_ctrl.op      = second ? gda_pkg::ALU_SUB : gda_pkg::ALU_ADD;
        alu_ctrl.operand = {{(gda_pkg::ACC_W-gda_pkg::TAIL_W){terms.tail[gda_pkg::TAIL_W-1]}},
                            terms.tail};
      end
      gda_pkg::ST_OFF: begin
        alu_ctrl.op      = (item.func == gda_pkg::FUNC_ADD) ? gda_pkg::ALU_ADD
                                                            : gda_pkg::ALU_SUB;
        alu_ctrl.operand = gda_pkg::ACC_W'(item.offset_days);
      end
      gda_pkg::ST_BASE: begin
        alu_ctrl.op      = gda_pkg::ALU_SUB;
        alu_ctrl.operand = gda_pkg::ACC_W'(gda_pkg::SERIAL_BASE);
      end
      gda_pkg::ST_CHECK: begin
        alu_ctrl.op      = gda_pkg::ALU_HOLD;
        alu_ctrl.operand = gda_pkg::ACC_W'(gda_pkg::SPAN_MAX);
      end
      gda_pkg::ST_YEAR: begin
        alu_ctrl.op      = gda_pkg::ALU_CSUB;
        alu_ctrl.operand = gda_pkg::ACC_W'(year_len);
      end
      gda_pkg::ST_MONTH: begin
        alu_ctrl.op      = (mon == gda_pkg::LAST_MONTH) ? gda_pkg::ALU_HOLD
                                                        : gda_pkg::ALU_CSUB;
        alu_ctrl.operand = gda_pkg::ACC_W'(mon_len);
      end
      default: begin
        alu_ctrl.op      = gda_pkg::ALU_HOLD;
        alu_ctrl.operand = '0;
      end
    endcase
  end

  // result item
  always_comb begin
    res = '0;
    case (item.func)
      gda_pkg::FUNC_ADD, gda_pkg::FUNC_SUB: begin
        if (oor) begin
          res.status = 1'b1;
        end else begin
          res.result_year  = year_cnt;
          res.result_month = gda_pkg::MONTH_W'(mon) + gda_pkg::MONTH_W'(1);
          res.result_day   = alu_stat.acc[gda_pkg::DAY_W-1:0] + gda_pkg::DAY_W'(1);
        end
      end
      gda_pkg::FUNC_DIFF: begin
        if (acc_s > gda_pkg::DIFF_HI) begin
          res.days_between = gda_pkg::DIFF_HI[gda_pkg::DIFF_W-1:0];
        end else if (acc_s < gda_pkg::DIFF_LO) begin
          res.days_between = gda_pkg::DIFF_LO[gda_pkg::DIFF_W-1:0];
        end else begin
          res.days_between = alu_stat.acc[gda_pkg::DIFF_W-1:0];
        end
      end
      gda_pkg::FUNC_CMP: begin
        res.is_less  = (item.year < item.other_year)
                    || ((item.year == item.other_year) && (item.month < item.other_month))
                    || ((item.year == item.other_year) && (item.month == item.other_month)
                        && (item.day < item.other_day));
        res.is_equal = (item.year == item.other_year) && (item.month == item.other_month)
                    && (item.day == item.other_day);
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= gda_pkg::ST_IDLE;
      second <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        gda_pkg::ST_IDLE: begin
          if (in_valid) begin
            item   <= in_data;
            second <= 1'b0;
          end
        end
        gda_pkg::ST_T4: begin
          if (item.func == gda_pkg::FUNC_DIFF) begin
            second <= 1'b1;
          end
        end
        gda_pkg::ST_CHECK: begin
          oor      <= alu_stat.acc[gda_pkg::ACC_W-1] || alu_stat.ge;
          year_cnt <= gda_pkg::YEAR_W'(1);
          mod4     <= 2'd1;
          mod100   <= gda_pkg::M100_W'(1);
          mod400   <= gda_pkg::M400_W'(1);
          mon      <= '0;
        end
        gda_pkg::ST_YEAR: begin
          if (alu_stat.ge) begin
            year_cnt <= year_cnt + gda_pkg::YEAR_W'(1);
            mod4     <= mod4 + 2'd1;
            mod100   <= (mod100 == gda_pkg::MOD100_TOP) ? '0 : mod100 + gda_pkg::M100_W'(1);
            mod400   <= (mod400 == gda_pkg::MOD400_TOP) ? '0 : mod400 + gda_pkg::M400_W'(1);
          end
        end
        gda_pkg::ST_MONTH: begin
          if (alu_stat.ge && (mon != gda_pkg::LAST_MONTH)) begin
            mon <= mon + gda_pkg::MIDX_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/gregorian_date_arithmetic_top.sv -----
`timescale 1ns / 1ps
// compare goes straight to the result; days between builds both serial day numbers;
//   add or subtract skips the walk when out of range, else walks whole years, then
//   whole months, back to a date
// the year walk does one subtract a cycle on the shared accumulator
// one item at a time; the next transfer is taken once the result is in the output register
// reset (rst, synchronous, active high) clears the sequencer and the output valid
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_top
// Gregorian date unit: add or subtract days, days between two dates, and
// date compare, on a small sequencer around one shared accumulator.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic_top (
  input  logic       clk,
  input  logic       rst,
  gda_in_if.sink     in_item,
  gda_out_if.source  out_item
);

  gda_pkg::date_t     sel_date;
  logic               term_load;
  gda_pkg::terms_t    terms;
  gda_pkg::alu_ctrl_t alu_ctrl;
  gda_pkg::alu_stat_t alu_stat;
  logic               res_valid;
  logic               res_ready;
  gda_pkg::out_item_t res;

  logic               out_valid;
  gda_pkg::out_item_t out_data;

  gda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_item.valid),
    .in_data   (in_item.data),
    .in_ready  (in_item.ready),
    .sel_date  (sel_date),
    .term_load (term_load),
    .terms     (terms),
    .alu_ctrl  (alu_ctrl),
    .alu_stat  (alu_stat),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  gda_terms u_terms (
    .clk   (clk),
    .load  (term_load),
    .date  (sel_date),
    .terms (terms)
  );

  gda_alu u_alu (
    .clk  (clk),
    .ctrl (alu_ctrl),
    .stat (alu_stat)
  );

  // output register
  assign res_ready = !out_valid || out_item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= res;
    end
  end

  assign out_item.valid = out_valid;
  assign out_item.data  = out_data;

endmodule
